FILE: sv/fixed_point_q24_8_alu_top_defines.svh
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define FPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed-point ALU check failed");

// Check that cons holds in the cycle after ante.
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed-point ALU check failed");

`else

`define FPA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int FRAC_BITS = 8;

    // quotient bits resolved by the divider stages
    localparam int DIV_BITS = 33;

    localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);
    // largest magnitudes that still fit a signed 32-bit result
    localparam logic [32:0] POS_LIMIT  = 33'h0_7FFF_FFFF;
    localparam logic [32:0] NEG_LIMIT  = 33'h0_8000_0000;
    localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN    = 32'h8000_0000;

    typedef enum logic [3:0] {
        FN_ADD    = 4'd0,
        FN_SUB    = 4'd1,
        FN_MUL    = 4'd2,
        FN_DIV    = 4'd3,
        FN_GT     = 4'd4,
        FN_GE     = 4'd5,
        FN_LT     = 4'd6,
        FN_LE     = 4'd7,
        FN_EQ     = 4'd8,
        FN_NE     = 4'd9,
        FN_MIN    = 4'd10,
        FN_MAX    = 4'd11,
        FN_INC    = 4'd12,
        FN_DEC    = 4'd13,
        FN_TO_INT = 4'd14
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // one pipeline slot
    typedef struct packed {
        t_func                 func;
        logic [31:0]           res;
        logic                  cmp;
        t_status               st;
        logic                  neg;
        logic                  ovf;
        logic [63:0]           num;
        logic [64:0]           dsh;
        logic [DIV_BITS-1:0]   quo;
    } t_pipe;

endpackage

FILE: sv/fixed_point_q24_8_alu_top.sv
// Fixed-point Q24.8 ALU: 36-stage pipeline, one operation accepted per cycle.
// Every op passes in order through the operand stage, round/range stage,
// 33 divider stages and output register before its result is valid.
// Throughput: one transfer per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
`timescale 1ns / 1ps

`include "fixed_point_q24_8_alu_top_defines.svh"

module fixed_point_q24_8_alu_top
    import fpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_compare_true,
    output logic [1:0]         o_status
);

    logic en;

    logic  r_v1, r_v2;
    t_pipe r_s1, r_s2, n_s1, n_s2;

    logic  r_dv_v [DIV_BITS];
    t_pipe r_dv   [DIV_BITS];
    t_pipe n_dv   [DIV_BITS];

    logic        r_out_v;
    logic [31:0] r_out_res, n_out_res;
    logic        r_out_cmp;
    t_status     r_out_st, n_out_st;

    // advance whenever the output slot is free or being taken
    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;

    // stage 1: simple ops, multiply, divider operand prep
    logic [32:0] w_sum, w_diff, w_inc, w_dec;
    logic [31:0] w_mag_a, w_mag_b;
    logic [63:0] w_na;

    always_comb begin
        w_sum   = {i_operand_a[31], i_operand_a} + {i_operand_b[31], i_operand_b};
        w_diff  = {i_operand_a[31], i_operand_a} - {i_operand_b[31], i_operand_b};
        w_inc   = {i_operand_a[31], i_operand_a} + 33'd1;
        w_dec   = {i_operand_a[31], i_operand_a} - 33'd1;
        w_mag_a = i_operand_a[31] ? 32'(-i_operand_a) : i_operand_a;
        w_mag_b = i_operand_b[31] ? 32'(-i_operand_b) : i_operand_b;
        w_na    = {32'd0, w_mag_a} << FRAC_BITS;

        n_s1      = '0;
        n_s1.func = t_func'(i_func);
        n_s1.st   = ST_OK;
        case (t_func'(i_func))
            FN_ADD: begin
                n_s1.res = w_sum[31:0];
                if (w_sum[32] != w_sum[31]) begin
                    n_s1.res = w_sum[32] ? SAT_MIN : SAT_MAX;
                    n_s1.st  = ST_SAT;
                end
            end
            FN_SUB: begin
                n_s1.res = w_diff[31:0];
                if (w_diff[32] != w_diff[31]) begin
                    n_s1.res = w_diff[32] ? SAT_MIN : SAT_MAX;
                    n_s1.st  = ST_SAT;
                end
            end
            FN_INC: begin
                n_s1.res = w_inc[31:0];
                if (w_inc[32] != w_inc[31]) begin
                    n_s1.res = SAT_MAX;
                    n_s1.st  = ST_SAT;
                end
            end
            FN_DEC: begin
                n_s1.res = w_dec[31:0];
                if (w_dec[32] != w_dec[31]) begin
                    n_s1.res = SAT_MIN;
                    n_s1.st  = ST_SAT;
                end
            end
            FN_MUL: begin
                n_s1.num = w_mag_a * w_mag_b;
                n_s1.neg = i_operand_a[31] ^ i_operand_b[31];
            end
            FN_DIV: begin
                if (i_operand_b == 32'sd0) begin
                    n_s1.st = ST_DIV0;
                end
                n_s1.num = (w_na << 1) + {32'd0, w_mag_b};
                n_s1.dsh = {w_mag_b, 1'b0, 32'd0};
                n_s1.neg = i_operand_a[31] ^ i_operand_b[31];
            end
            FN_GT:     n_s1.cmp = (i_operand_a >  i_operand_b);
            FN_GE:     n_s1.cmp = (i_operand_a >= i_operand_b);
            FN_LT:     n_s1.cmp = (i_operand_a <  i_operand_b);
            FN_LE:     n_s1.cmp = (i_operand_a <= i_operand_b);
            FN_EQ:     n_s1.cmp = (i_operand_a == i_operand_b);
            FN_NE:     n_s1.cmp = (i_operand_a != i_operand_b);
            FN_MIN:    n_s1.res = (i_operand_a < i_operand_b) ? i_operand_a : i_operand_b;
            FN_MAX:    n_s1.res = (i_operand_a > i_operand_b) ? i_operand_a : i_operand_b;
            FN_TO_INT: n_s1.res = 32'(i_operand_a >>> FRAC_BITS);
            default:   n_s1.res = '0;
        endcase
    end

    // stage 2: round the product, check quotient range before dividing
    logic [63:0] w_qm;
    logic [65:0] w_num66;
    logic [65:0] w_dlim;

    always_comb begin
        w_qm    = (r_s1.num + ROUND_HALF) >> FRAC_BITS;
        w_num66 = {2'b00, r_s1.num};
        w_dlim  = {r_s1.dsh, 1'b0};
        n_s2    = r_s1;
        if (r_s1.func == FN_MUL) begin
            n_s2.ovf = |w_qm[63:DIV_BITS];
            n_s2.quo = w_qm[DIV_BITS-1:0];
        end else if (r_s1.func == FN_DIV) begin
            n_s2.ovf = (w_num66 >= w_dlim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    // divider stages: one quotient bit each
    genvar g;
    generate
        for (g = 0; g < DIV_BITS; g++) begin : g_div
            if (g == 0) begin : g_first
                fpa_div_step u_step (.i_stage(r_s2), .o_stage(n_dv[g]));
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_dv_v[g] <= 1'b0;
                    end else if (en) begin
                        r_dv_v[g] <= r_v2;
                    end
                end
            end else begin : g_rest
                fpa_div_step u_step (.i_stage(r_dv[g-1]), .o_stage(n_dv[g]));
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_dv_v[g] <= 1'b0;
                    end else if (en) begin
                        r_dv_v[g] <= r_dv_v[g-1];
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[g] <= n_dv[g];
                end
            end
        end
    endgenerate

    // final stage: sign and saturate multiply and divide results
    t_pipe w_last;
    logic  w_big;

    always_comb begin
        w_last    = r_dv[DIV_BITS-1];
        w_big     = w_last.ovf ||
                    (w_last.neg ? (w_last.quo > NEG_LIMIT) : (w_last.quo > POS_LIMIT));
        n_out_res = w_last.res;
        n_out_st  = w_last.st;
        if ((w_last.func == FN_MUL || w_last.func == FN_DIV) && w_last.st != ST_DIV0) begin
            if (w_big) begin
                n_out_res = w_last.neg ? SAT_MIN : SAT_MAX;
                n_out_st  = ST_SAT;
            end else begin
                n_out_res = w_last.neg ? 32'(-w_last.quo[31:0]) : w_last.quo[31:0];
                n_out_st  = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[DIV_BITS-1];
        end
        if (en) begin
            r_out_res <= n_out_res;
            r_out_cmp <= w_last.cmp;
            r_out_st  <= n_out_st;
        end
    end

    assign o_valid        = r_out_v;
    assign o_result_value = r_out_res;
    assign o_compare_true = r_out_cmp;
    assign o_status       = r_out_st;

    // checks
    `FPA_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && !o_stall, r_v1)
    `FPA_ASSERT_SAME(a_cmp_clean, i_clk, i_rst_n, o_valid && o_compare_true, o_result_value == 32'sd0 && o_status == ST_OK)
    `FPA_ASSERT_SAME(a_div0_zero, i_clk, i_rst_n, o_valid && o_status == ST_DIV0, o_result_value == 32'sd0 && !o_compare_true)

endmodule

FILE: sv/fpa_div_step.sv
// One restoring step of the pipelined divider: resolves one quotient bit.
`timescale 1ns / 1ps

module fpa_div_step
    import fpa_pkg::*;
(
    input  t_pipe i_stage,
    output t_pipe o_stage
);

    logic [64:0] w_num_ext;
    logic        w_fit;

    assign w_num_ext = {1'b0, i_stage.num};
    assign w_fit     = (w_num_ext >= i_stage.dsh);

    // subtract the shifted divisor when it fits, shift in the quotient bit
    always_comb begin
        o_stage = i_stage;
        if (i_stage.func == FN_DIV) begin
            if (w_fit) begin
                o_stage.num = 64'(w_num_ext - i_stage.dsh);
            end
            o_stage.quo = {i_stage.quo[DIV_BITS-2:0], w_fit};
            o_stage.dsh = i_stage.dsh >> 1;
        end
    end

endmodule
